// File: rtl/lqg_pkg.sv
// package with constants, types and arithmetic helpers for the lqg observer step
`timescale 1ns / 1ps
package lqg_pkg;

    localparam int MaxJoints = 4;
    localparam int FracBits  = 16;
    localparam int Nx        = 2 * MaxJoints;
    localparam int BaseA     = MaxJoints * Nx;
    localparam int BaseB     = BaseA + Nx * Nx;
    localparam int BaseL     = BaseB + Nx * MaxJoints;
    localparam int BaseU     = BaseL + Nx * MaxJoints;
    localparam int CoefDepth = BaseU + MaxJoints;
    localparam int DtBits    = 16;

    localparam int CoefAw = $clog2(CoefDepth);
    localparam int EstAw  = $clog2(Nx);
    localparam int JntAw  = (MaxJoints > 1) ? $clog2(MaxJoints) : 1;

    // request function codes
    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_MEAS  = 2'd1,
        FUNC_WEST  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_STEP  = 2'd0,
        REG_LIMIT = 2'd1,
        REG_JNT   = 2'd2,
        REG_ACT   = 2'd3
    } reg_idx_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_U_RD,     // accumulate -K*xhat for one actuator
        ST_U_FIN,    // saturate util; u_eq is added in ST_TAU
        ST_TAU,
        ST_X_RD,     // accumulate one row of xdot
        ST_X_FIN,
        ST_E_MUL,    // dt * xdot
        ST_E_FIN,
        ST_INNOV,
        ST_MARGIN,
        ST_EMIT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else return v[31:0];
    endfunction

    // round to nearest, ties toward +inf, then shift by sh
    function automatic logic signed [65:0] rnd_shift(input logic signed [63:0] p,
                                                     input int sh);
        logic signed [65:0] t;
        t = 66'(p) + (66'sd1 <<< (sh - 1));
        return t >>> sh;
    endfunction

endpackage

// File: rtl/lqg_observer_feedback_step.sv
// top level of the lqg observer tick: coefficient store, sequencer and shared mac
`timescale 1ns / 1ps
// LQG output-feedback regulator tick, signed Q16.16 with saturation.
// Requests enter on s_axis (tdata: func, index, value, ref_value; tlast: last).
// Load, measurement without last, estimate write and clear complete on
// acceptance. A measurement with last runs the tick on one shared 32x32
// multiplier with a registered product and a 66-bit accumulator, driven
// from a single-port coefficient memory with registered read; each term
// has a read-issue phase and then a multiply phase. The tick makes
// m*2nj + 2nj*(2nj+m+nj) + m coefficient reads before the first torque
// is offered.
// Torques leave on m_axis, one per actuated joint (tdata: torque,
// actuator_index, final_torque, trust_ok, margin); tlast marks the last one.
// While the tick runs or results wait, s_axis_tready is low. A stalled
// receiver holds the current result; nothing is dropped.
// Reset (aresetn low, synchronous) clears the estimate, deviations and
// registers to their defaults; the coefficient store stays unwritten.
// Configuration writes via cfg_we/cfg_index/cfg_data act at once.
module lqg_observer_feedback_step (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // func[1:0], index[9:2], value[41:10], ref_value[73:42], zero pad
    input  logic [79:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // torque[31:0], actuator_index[35:32], final_torque[36], trust_ok[37],
    // margin[69:38], zero pad
    output logic [71:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data
);

    localparam int J  = lqg_pkg::MaxJoints;
    localparam int NX = lqg_pkg::Nx;

    // request fields
    logic [1:0]         in_func;
    logic [7:0]         in_index;
    logic signed [31:0] in_value, in_ref;
    assign in_func  = s_axis_tdata[1:0];
    assign in_index = s_axis_tdata[9:2];
    assign in_value = s_axis_tdata[41:10];
    assign in_ref   = s_axis_tdata[73:42];

    // configuration registers
    logic [15:0] step_reg;
    logic [30:0] limit_reg;
    logic [4:0]  jnt_reg, act_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= 16'd66;
            limit_reg <= 31'd65536;
            jnt_reg   <= 5'd1;
            act_reg   <= 5'd1;
        end else if (cfg_we) begin
            unique case (lqg_pkg::reg_idx_t'(cfg_index))
                lqg_pkg::REG_STEP:  step_reg  <= cfg_data[15:0];
                lqg_pkg::REG_LIMIT: limit_reg <= cfg_data;
                lqg_pkg::REG_JNT:   jnt_reg   <= cfg_data[4:0];
                lqg_pkg::REG_ACT:   act_reg   <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // clamped joint counts
    logic [4:0] nj, m;
    always_comb begin
        nj = jnt_reg;
        if (nj == 5'd0) nj = 5'd1;
        if (nj > 5'(J)) nj = 5'(J);
        m = (act_reg > 5'(J)) ? 5'(J) : act_reg;
    end
    logic [5:0] nx;
    assign nx = {nj, 1'b0};

    lqg_pkg::state_t state_reg, state_next;
    logic s_fire, m_fire;
    assign s_axis_tready = (state_reg == lqg_pkg::ST_IDLE);
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;

    // sequencer counters
    logic [4:0] row_reg, row_next;   // actuator or estimate row
    logic [5:0] k_reg, k_next;       // term within a row
    logic       ph_reg, ph_next;     // 0 issue read, 1 multiply

    // coefficient memory
    logic [31:0]                 coef_mem [lqg_pkg::CoefDepth];
    logic [lqg_pkg::CoefAw-1:0]  c_addr;
    logic signed [31:0]          c_rd_reg;
    always_ff @(posedge aclk) begin
        if (s_fire && in_func == lqg_pkg::FUNC_LOAD && in_index < 8'(lqg_pkg::CoefDepth))
            coef_mem[in_index[lqg_pkg::CoefAw-1:0]] <= in_value;
        c_rd_reg <= coef_mem[c_addr];
    end

    // state arrays
    logic signed [31:0] est_reg [NX];
    logic signed [31:0] dev_reg [J];
    logic signed [31:0] util_reg [J];
    logic signed [31:0] tau_reg [J];
    logic signed [31:0] xdot_reg [NX];

    // term selection for the multiplier
    logic [1:0] sect;     // 0 A*x, 1 B*u, 2 L*dev
    logic [5:0] kk;
    always_comb begin
        c_addr = '0;
        sect = 2'd0;
        kk = k_reg;
        unique case (state_reg)
            lqg_pkg::ST_U_RD:
                c_addr = lqg_pkg::CoefAw'(row_reg * NX + k_reg);
            lqg_pkg::ST_U_FIN, lqg_pkg::ST_TAU:
                c_addr = lqg_pkg::CoefAw'(lqg_pkg::BaseU + row_reg);
            lqg_pkg::ST_X_RD: begin
                if (k_reg < nx) begin
                    c_addr = lqg_pkg::CoefAw'(lqg_pkg::BaseA + row_reg * NX + k_reg);
                end else if (k_reg < nx + 6'(m)) begin
                    sect = 2'd1;
                    kk = k_reg - nx;
                    c_addr = lqg_pkg::CoefAw'(lqg_pkg::BaseB + row_reg * J + kk);
                end else begin
                    sect = 2'd2;
                    kk = k_reg - nx - 6'(m);
                    c_addr = lqg_pkg::CoefAw'(lqg_pkg::BaseL + row_reg * J + kk);
                end
            end
            default: ;
        endcase
    end

    // operand latched with the read, product registered
    logic signed [31:0] opb_reg;
    logic signed [63:0] prod_reg;
    logic               pv_reg;
    logic signed [65:0] acc_reg;
    logic signed [31:0] opb_sel;
    always_comb begin
        opb_sel = est_reg[kk[lqg_pkg::EstAw-1:0]];
        if (sect == 2'd1) opb_sel = util_reg[kk[lqg_pkg::JntAw-1:0]];
        else if (sect == 2'd2) opb_sel = dev_reg[kk[lqg_pkg::JntAw-1:0]];
    end

    // row totals
    logic [5:0] row_terms;
    assign row_terms = (state_reg == lqg_pkg::ST_U_RD) ? nx : nx + 6'(m) + 6'(nj);

    // innovation search
    logic [31:0]        innov_reg;
    logic signed [32:0] dj;
    logic [31:0]        adj;
    assign dj  = 33'(dev_reg[row_reg[lqg_pkg::JntAw-1:0]])
               - 33'(est_reg[row_reg[lqg_pkg::EstAw-1:0]]);
    assign adj = dj[32] ? 32'(-dj) : dj[31:0];

    logic signed [32:0] marg;
    assign marg = 33'($signed({2'b00, limit_reg})) - 33'($signed({1'b0, innov_reg}));
    logic               ok_reg;
    logic signed [31:0] msat_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        row_next = row_reg;
        k_next = k_reg;
        ph_next = ph_reg;
        unique case (state_reg)
            lqg_pkg::ST_IDLE:
                if (s_fire && in_func == lqg_pkg::FUNC_MEAS && s_axis_tlast) begin
                    row_next = '0; k_next = '0; ph_next = 1'b0;
                    state_next = (m == 5'd0) ? lqg_pkg::ST_X_RD : lqg_pkg::ST_U_RD;
                end
            lqg_pkg::ST_U_RD, lqg_pkg::ST_X_RD: begin
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    if (k_reg == row_terms - 6'd1) begin
                        k_next = '0;
                        state_next = (state_reg == lqg_pkg::ST_U_RD) ?
                                     lqg_pkg::ST_U_FIN : lqg_pkg::ST_X_FIN;
                    end else begin
                        k_next = k_reg + 6'd1;
                    end
                end
            end
            lqg_pkg::ST_U_FIN: state_next = lqg_pkg::ST_TAU;
            lqg_pkg::ST_TAU: begin
                ph_next = 1'b0;
                if (row_reg == m - 5'd1) begin
                    row_next = '0; state_next = lqg_pkg::ST_X_RD;
                end else begin
                    row_next = row_reg + 5'd1; state_next = lqg_pkg::ST_U_RD;
                end
            end
            lqg_pkg::ST_X_FIN: begin
                ph_next = 1'b0;
                if (row_reg == nx[4:0] - 5'd1) begin
                    row_next = '0; state_next = lqg_pkg::ST_E_MUL;
                end else begin
                    row_next = row_reg + 5'd1; state_next = lqg_pkg::ST_X_RD;
                end
            end
            lqg_pkg::ST_E_MUL: state_next = lqg_pkg::ST_E_FIN;
            lqg_pkg::ST_E_FIN:
                if (row_reg == nx[4:0] - 5'd1) begin
                    row_next = '0; state_next = lqg_pkg::ST_INNOV;
                end else begin
                    row_next = row_reg + 5'd1; state_next = lqg_pkg::ST_E_MUL;
                end
            lqg_pkg::ST_INNOV:
                if (row_reg == nj - 5'd1) begin
                    row_next = '0; state_next = lqg_pkg::ST_MARGIN;
                end else begin
                    row_next = row_reg + 5'd1;
                end
            lqg_pkg::ST_MARGIN:
                state_next = (m == 5'd0) ? lqg_pkg::ST_IDLE : lqg_pkg::ST_EMIT;
            lqg_pkg::ST_EMIT:
                if (m_fire) begin
                    if (row_reg == m - 5'd1) state_next = lqg_pkg::ST_IDLE;
                    row_next = row_reg + 5'd1;
                end
            default: state_next = lqg_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lqg_pkg::ST_IDLE;
            row_reg <= '0; k_reg <= '0; ph_reg <= 1'b0; pv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg <= row_next; k_reg <= k_next; ph_reg <= ph_next;
            pv_reg <= ph_reg && (state_reg == lqg_pkg::ST_U_RD ||
                                 state_reg == lqg_pkg::ST_X_RD);
        end
    end

    // datapath: multiply, accumulate, writebacks
    function automatic logic signed [65:0] rnd_dt(input logic signed [63:0] p);
        return lqg_pkg::rnd_shift(p, lqg_pkg::DtBits);
    endfunction
    logic signed [65:0] eprod;
    assign eprod = rnd_dt(prod_reg);

    always_ff @(posedge aclk) begin
        if (!ph_reg) opb_reg <= opb_sel;
        if (state_reg == lqg_pkg::ST_E_MUL)
            prod_reg <= $signed({1'b0, step_reg}) * xdot_reg[row_reg[lqg_pkg::EstAw-1:0]];
        else
            prod_reg <= c_rd_reg * opb_reg;
        if (state_reg == lqg_pkg::ST_IDLE || state_reg == lqg_pkg::ST_TAU ||
            state_reg == lqg_pkg::ST_X_FIN)
            acc_reg <= '0;
        else if (pv_reg)
            acc_reg <= acc_reg + lqg_pkg::rnd_shift(prod_reg, lqg_pkg::FracBits);
        if (state_reg == lqg_pkg::ST_U_FIN)
            util_reg[row_reg[lqg_pkg::JntAw-1:0]] <= lqg_pkg::sat32(-(acc_reg
                + lqg_pkg::rnd_shift(prod_reg, lqg_pkg::FracBits)));
        if (state_reg == lqg_pkg::ST_TAU)
            tau_reg[row_reg[lqg_pkg::JntAw-1:0]] <= lqg_pkg::sat32(66'(c_rd_reg)
                + 66'(util_reg[row_reg[lqg_pkg::JntAw-1:0]]));
        if (state_reg == lqg_pkg::ST_X_FIN)
            xdot_reg[row_reg[lqg_pkg::EstAw-1:0]] <= lqg_pkg::sat32(acc_reg
                + lqg_pkg::rnd_shift(prod_reg, lqg_pkg::FracBits));
        if (state_reg == lqg_pkg::ST_INNOV)
            innov_reg <= (row_reg == 5'd0 || adj > innov_reg) ? adj : innov_reg;
        if (state_reg == lqg_pkg::ST_MARGIN) begin
            ok_reg <= !marg[32];
            msat_reg <= lqg_pkg::sat32(66'(marg));
        end
    end

    // estimate and deviation state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NX; i++) est_reg[i] <= '0;
            for (int i = 0; i < J; i++) dev_reg[i] <= '0;
        end else if (state_reg == lqg_pkg::ST_E_FIN) begin
            est_reg[row_reg[lqg_pkg::EstAw-1:0]] <= lqg_pkg::sat32(
                66'(est_reg[row_reg[lqg_pkg::EstAw-1:0]]) + eprod);
        end else if (s_fire) begin
            unique case (lqg_pkg::func_t'(in_func))
                lqg_pkg::FUNC_MEAS:
                    if (in_index < 8'(J))
                        dev_reg[in_index[lqg_pkg::JntAw-1:0]] <=
                            lqg_pkg::sat32(66'(in_value) - 66'(in_ref));
                lqg_pkg::FUNC_WEST:
                    if (in_index < 8'(NX))
                        est_reg[in_index[lqg_pkg::EstAw-1:0]] <= in_value;
                lqg_pkg::FUNC_CLEAR:
                    for (int i = 0; i < NX; i++) est_reg[i] <= '0;
                default: ;
            endcase
        end
    end

    // result channel
    logic [3:0] aidx;
    assign aidx = row_reg[3:0];
    assign m_axis_tvalid = (state_reg == lqg_pkg::ST_EMIT);
    assign m_axis_tlast  = (row_reg == m - 5'd1);
    assign m_axis_tdata  = {2'b00, msat_reg, ok_reg, m_axis_tlast, aidx,
                            tau_reg[row_reg[lqg_pkg::JntAw-1:0]]};

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request accepted while results pending");
    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(row_reg))
        else $error("result lost under stall");
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> row_reg < m)
        else $error("actuator index out of range");
`endif

endmodule

// File: test/tb.sv
// self-checking testbench for the lqg observer feedback step
`timescale 1ns / 1ps
module tb;

    localparam int TickWait = 400;
    localparam int CycleLimit = 1500000;

    // one torque result as the block reports it, lowest field last
    typedef struct packed {
        logic [31:0] marg;
        logic        ok;
        logic        fin;
        logic [3:0]  aidx;
        logic [31:0] torque;
    } torque_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // func[1:0], index[9:2], value[41:10], ref_value[73:42], zero pad
    logic [79:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // torque[31:0], actuator_index[35:32], final_torque[36], trust_ok[37], margin[69:38]
    logic [71:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = lqg_pkg::REG_STEP;
    logic [30:0]  cfg_data = '0;

    // predictor state
    logic signed [31:0] coef_m [lqg_pkg::CoefDepth];
    logic signed [31:0] est_m [lqg_pkg::Nx];
    logic signed [31:0] dev_m [lqg_pkg::MaxJoints];
    logic [15:0] step_m;
    logic [30:0] limit_m;
    logic [4:0]  jnt_m;
    logic [4:0]  act_m;

    torque_t torque_q[$];
    int  errors = 0;
    int  cycles = 0;
    int  hold_len = 0;
    int  n_sent = 0;
    bit  steady = 0;

    lqg_observer_feedback_step DUT (.*);

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [31:0] clip(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // round to nearest with ties up, then drop f fraction bits
    function automatic longint round_q(longint p, int f);
        longint t;
        t = p + (longint'(1) <<< (f - 1));
        return t >>> f;
    endfunction

    function automatic longint qmul(logic signed [31:0] a, logic signed [31:0] b);
        return round_q(longint'(a) * longint'(b), lqg_pkg::FracBits);
    endfunction

    // control law, euler observer update and innovation margin
    function automatic void predict_tick();
        int nj, m, nx;
        longint s, innov, marg, d;
        logic signed [31:0] util [lqg_pkg::MaxJoints];
        logic signed [31:0] tau [lqg_pkg::MaxJoints];
        logic signed [31:0] xdot [lqg_pkg::Nx];
        torque_t r;
        nj = jnt_m;
        m = act_m;
        if (nj < 1) nj = 1;
        if (nj > lqg_pkg::MaxJoints) nj = lqg_pkg::MaxJoints;
        if (m > lqg_pkg::MaxJoints) m = lqg_pkg::MaxJoints;
        nx = 2 * nj;
        for (int a = 0; a < m; a++) begin
            s = 0;
            for (int c = 0; c < nx; c++) s += qmul(coef_m[a * lqg_pkg::Nx + c], est_m[c]);
            util[a] = clip(-s);
            tau[a] = clip(longint'(coef_m[lqg_pkg::BaseU + a]) + longint'(util[a]));
        end
        for (int rw = 0; rw < nx; rw++) begin
            s = 0;
            for (int c = 0; c < nx; c++)
                s += qmul(coef_m[lqg_pkg::BaseA + rw * lqg_pkg::Nx + c], est_m[c]);
            for (int a = 0; a < m; a++)
                s += qmul(coef_m[lqg_pkg::BaseB + rw * lqg_pkg::MaxJoints + a], util[a]);
            for (int j = 0; j < nj; j++)
                s += qmul(coef_m[lqg_pkg::BaseL + rw * lqg_pkg::MaxJoints + j], dev_m[j]);
            xdot[rw] = clip(s);
        end
        for (int rw = 0; rw < nx; rw++)
            est_m[rw] = clip(longint'(est_m[rw])
                             + round_q(longint'({1'b0, step_m}) * longint'(xdot[rw]),
                                       lqg_pkg::DtBits));
        innov = 0;
        for (int j = 0; j < nj; j++) begin
            d = longint'(dev_m[j]) - longint'(est_m[j]);
            if (d < 0) d = -d;
            if (d > innov) innov = d;
        end
        marg = longint'({1'b0, limit_m}) - innov;
        for (int a = 0; a < m; a++) begin
            r.torque = tau[a];
            r.aidx = a[3:0];
            r.fin = (a == m - 1);
            r.ok = (marg >= 0);
            r.marg = clip(marg);
            torque_q = {torque_q, r};
        end
    endfunction

    function automatic void predict_request(lqg_pkg::func_t f, logic [7:0] idx,
                                            logic signed [31:0] val,
                                            logic signed [31:0] refv, logic lst);
        case (f)
            lqg_pkg::FUNC_LOAD: if (idx < lqg_pkg::CoefDepth) coef_m[idx] = val;
            lqg_pkg::FUNC_MEAS: begin
                if (idx < lqg_pkg::MaxJoints)
                    dev_m[idx] = clip(longint'(val) - longint'(refv));
                if (lst) predict_tick();
            end
            lqg_pkg::FUNC_WEST: if (idx < lqg_pkg::Nx) est_m[idx] = val;
            default: for (int i = 0; i < lqg_pkg::Nx; i++) est_m[i] = '0;
        endcase
    endfunction

    // send one request and wait for its handshake
    task automatic send_req(lqg_pkg::func_t f, logic [7:0] idx, logic signed [31:0] val,
                            logic signed [31:0] refv, logic lst);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, refv, val, idx, f};
        s_axis_tlast <= lst;
        do @(posedge aclk); while (!s_axis_tready);
        n_sent++;
        predict_request(f, idx, val, refv, lst);
    endtask

    // stop offering, wait for all results, then for a tick that returns nothing
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (torque_q.size() > 0) @(posedge aclk);
        repeat (TickWait) @(posedge aclk);
    endtask

    task automatic write_reg(lqg_pkg::reg_idx_t ri, logic [30:0] v);
        cfg_we <= 1'b1;
        cfg_index <= ri;
        cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (ri)
            lqg_pkg::REG_STEP:  step_m = v[15:0];
            lqg_pkg::REG_LIMIT: limit_m = v;
            lqg_pkg::REG_JNT:   jnt_m = v[4:0];
            default:            act_m = v[4:0];
        endcase
    endtask

    function automatic logic signed [31:0] near_one();
        return $signed(32'($urandom_range(0, 131071))) - 32'sd65536;
    endfunction

    function automatic logic signed [31:0] pos_val();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $signed(32'($urandom_range(0, 262143))) - 32'sd131072;
    endfunction

    // one well-formed tick: every used joint measured, the last with last set
    task automatic tick_seq();
        int nj;
        nj = (jnt_m < 1) ? 1 : (jnt_m > lqg_pkg::MaxJoints) ? lqg_pkg::MaxJoints : jnt_m;
        for (int j = 0; j < nj; j++)
            send_req(lqg_pkg::FUNC_MEAS, j[7:0], pos_val(), pos_val(), j == nj - 1);
    endtask

    // fill the whole coefficient store, plus ignored addresses
    task automatic test_coef_load();
        for (int i = 0; i < lqg_pkg::CoefDepth; i++)
            send_req(lqg_pkg::FUNC_LOAD, i[7:0], near_one(), 0, 1'b0);
        send_req(lqg_pkg::FUNC_LOAD, 8'(lqg_pkg::CoefDepth), 32'sh7fffffff, 0, 1'b1);
        send_req(lqg_pkg::FUNC_LOAD, 8'hff, 32'sh80000000, 32'sh7fffffff, 1'b1);
    endtask

    // field extremes and special cases
    task automatic test_directed();
        send_req(lqg_pkg::FUNC_WEST, 8'd0, 32'sh7fffffff, 0, 1'b0);
        send_req(lqg_pkg::FUNC_WEST, 8'd1, 32'sh80000000, 0, 1'b1);
        send_req(lqg_pkg::FUNC_WEST, 8'(lqg_pkg::Nx), 32'sh12345678, 0, 1'b0);
        send_req(lqg_pkg::FUNC_WEST, 8'hff, 32'shffffffff, 0, 1'b0);
        // deviation saturating both ways
        send_req(lqg_pkg::FUNC_MEAS, 8'd0, 32'sh80000000, 32'sh7fffffff, 1'b1);
        send_req(lqg_pkg::FUNC_MEAS, 8'd0, 32'sh7fffffff, 32'sh80000000, 1'b1);
        // joint index out of range still runs the tick
        send_req(lqg_pkg::FUNC_MEAS, 8'(lqg_pkg::MaxJoints), 32'sh00010000, 0, 1'b1);
        send_req(lqg_pkg::FUNC_MEAS, 8'hff, 32'shffffffff, 32'shffffffff, 1'b1);
        send_req(lqg_pkg::FUNC_CLEAR, 8'hff, 32'shffffffff, 32'shffffffff, 1'b1);
        send_req(lqg_pkg::FUNC_MEAS, 8'd0, 0, 0, 1'b1);
        // extreme gain then restore
        send_req(lqg_pkg::FUNC_LOAD, 8'd0, 32'sh7fffffff, 0, 1'b0);
        send_req(lqg_pkg::FUNC_LOAD, 8'(lqg_pkg::BaseU), 32'sh80000000, 0, 1'b0);
        send_req(lqg_pkg::FUNC_WEST, 8'd0, 32'sh7fffffff, 0, 1'b0);
        send_req(lqg_pkg::FUNC_MEAS, 8'd0, 32'sh01000000, 32'shff000000, 1'b1);
        send_req(lqg_pkg::FUNC_LOAD, 8'd0, 32'sh00008000, 0, 1'b0);
        send_req(lqg_pkg::FUNC_LOAD, 8'(lqg_pkg::BaseU), 32'sh00020000, 0, 1'b0);
        send_req(lqg_pkg::FUNC_CLEAR, 8'd0, 0, 0, 1'b0);
        drain();
    endtask

    // sweep register settings including the extremes and clamped counts
    task automatic test_config_sweep();
        logic [30:0] steps [4] = '{31'd0, 31'd65535, 31'd66, 31'd4096};
        logic [30:0] lims [4] = '{31'd0, 31'h7fffffff, 31'd65536, 31'd200000};
        logic [30:0] jnts [5] = '{31'd0, 31'd4, 31'd20, 31'd31, 31'd2};
        logic [30:0] acts [5] = '{31'd0, 31'd4, 31'd31, 31'd16, 31'd3};
        for (int k = 0; k < 5; k++) begin
            write_reg(lqg_pkg::REG_STEP, steps[k % 4]);
            write_reg(lqg_pkg::REG_LIMIT, lims[k % 4]);
            write_reg(lqg_pkg::REG_JNT, jnts[k]);
            write_reg(lqg_pkg::REG_ACT, acts[k]);
            tick_seq();
            tick_seq();
            drain();
        end
    endtask

    // mostly well-formed ticks with random content, some noise
    task automatic test_random(int n_items);
        int start;
        int iter;
        start = n_sent;
        iter = 0;
        while (n_sent - start < n_items) begin
            if (iter % 12 == 0) begin
                drain();
                write_reg(lqg_pkg::REG_STEP, 31'($urandom_range(0, 65535)));
                write_reg(lqg_pkg::REG_LIMIT, 31'($urandom_range(0, 300000)));
                write_reg(lqg_pkg::REG_JNT, 31'($urandom_range(1, 4)));
                write_reg(lqg_pkg::REG_ACT, 31'($urandom_range(1, 4)));
                steady = ((iter / 12) % 2 == 1);
            end
            case ($urandom_range(0, 9))
                0: send_req(lqg_pkg::FUNC_LOAD, 8'($urandom_range(0, lqg_pkg::CoefDepth - 1)),
                            near_one(), $urandom, 1'($urandom_range(0, 1)));
                1: send_req(lqg_pkg::FUNC_WEST, 8'($urandom_range(0, 9)), pos_val(),
                            $urandom, 1'b0);
                2: send_req(lqg_pkg::func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                            $urandom, $urandom, 1'b0);
                3: send_req(lqg_pkg::FUNC_CLEAR, 8'($urandom), $urandom, $urandom,
                            1'($urandom_range(0, 1)));
                default: tick_seq();
            endcase
            iter++;
        end
        steady = 0;
        drain();
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_backpressure();
        hold_len = 600;
        repeat (4) tick_seq();
        // sender pauses until every result has come back
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (torque_q.size() > 0) @(posedge aclk);
        repeat (3) tick_seq();
        drain();
    endtask

    // result receiver with random stalls and one long hold-off on request
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if (hold_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    // compare each accepted result with the oldest expected torque
    always @(posedge aclk) begin
        torque_t exp_r, got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[69:0];
            if (torque_q.size() == 0) begin
                $display("%0t unexpected torque: expected none, actual %h", $time, got);
                errors++;
            end else begin
                exp_r = torque_q.pop_front();
                if (got.torque !== exp_r.torque) begin
                    $display("%0t torque: expected %h actual %h", $time, exp_r.torque, got.torque);
                    errors++;
                end
                if (got.aidx !== exp_r.aidx) begin
                    $display("%0t actuator: expected %0d actual %0d", $time, exp_r.aidx, got.aidx);
                    errors++;
                end
                if (got.fin !== exp_r.fin || m_axis_tlast !== exp_r.fin) begin
                    $display("%0t final: expected %b actual %b/%b", $time, exp_r.fin, got.fin,
                             m_axis_tlast);
                    errors++;
                end
                if (got.ok !== exp_r.ok) begin
                    $display("%0t trust_ok: expected %b actual %b", $time, exp_r.ok, got.ok);
                    errors++;
                end
                if (got.marg !== exp_r.marg) begin
                    $display("%0t margin: expected %h actual %h", $time, exp_r.marg, got.marg);
                    errors++;
                end
            end
        end
    end

    // test sequence
    initial begin
        for (int i = 0; i < lqg_pkg::CoefDepth; i++) coef_m[i] = '0;
        for (int i = 0; i < lqg_pkg::Nx; i++) est_m[i] = '0;
        for (int i = 0; i < lqg_pkg::MaxJoints; i++) dev_m[i] = '0;
        step_m = 16'd66;
        limit_m = 31'd65536;
        jnt_m = 5'd1;
        act_m = 5'd1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_coef_load();
        test_directed();
        test_config_sweep();
        test_random(100);
        test_backpressure();
        drain();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
